### hw/rtl/cidb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cidb_pkg;

    localparam int OP_W   = 2;
    localparam int POS_W  = 9;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int STAT_W = 2;

    localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_CR    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_REM,
        S_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] read_value;
        logic [LEN_W-1:0]  text_length;
        t_status           status;
    } t_res;

endpackage

`default_nettype wire

### hw/rtl/cidb_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module cidb_mem #(
    parameter int DEPTH = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire logic [cidb_pkg::BYTE_W-1:0]  i_wr_data,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic      [cidb_pkg::BYTE_W-1:0]  o_rd_data
);
    import cidb_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/cidb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cidb_ctrl #(
    parameter int CAPACITY = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire cidb_pkg::t_op                   i_op,
    input  wire logic                            i_start_req,
    input  wire logic [cidb_pkg::POS_W-1:0]      i_position,
    input  wire logic [cidb_pkg::BYTE_W-1:0]     i_byte_value,
    input  wire logic                            i_slot_free,
    output logic                                 o_fin_valid,
    output cidb_pkg::t_res                       o_fin,
    output logic                                 o_wr_en,
    output logic [$clog2(CAPACITY)-1:0]          o_wr_addr,
    output logic [cidb_pkg::BYTE_W-1:0]          o_wr_data,
    output logic                                 o_rd_en,
    output logic [$clog2(CAPACITY)-1:0]          o_rd_addr,
    input  wire logic [cidb_pkg::BYTE_W-1:0]     i_rd_data
);
    import cidb_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_dst, n_dst;
    logic [AW-1:0]     r_pos, n_pos;
    logic [BYTE_W-1:0] r_val, n_val;
    t_res              r_res, n_res;

    logic          w_accept;
    logic [EW-1:0] w_pos_ext, w_cnt_ext, w_pos_p1;
    logic [CW-1:0] w_eff, w_cnt_m1, w_dst_m2, w_dst_p2;
    logic          w_cr, w_app_full, w_full;
    logic          w_ins_bad, w_pos_bad, w_pos_eq, w_pos_last;
    logic          w_ins_last, w_rem_last;

    // decode of the incoming transaction and shift loop bounds
    always_comb begin
        w_accept   = i_in_valid && (r_state == S_IDLE);
        w_pos_ext  = EW'(i_position);
        w_cnt_ext  = EW'(r_count);
        w_pos_p1   = w_pos_ext + EW'(1);
        w_eff      = i_start_req ? '0 : r_count;
        w_cnt_m1   = r_count - CW'(1);
        w_cr       = (i_byte_value == CR_BYTE);
        w_app_full = (w_eff >= CW'(CAPACITY));
        w_full     = (r_count >= CW'(CAPACITY));
        w_ins_bad  = (w_pos_ext > w_cnt_ext);
        w_pos_bad  = (w_pos_ext >= w_cnt_ext);
        w_pos_eq   = (w_pos_ext == w_cnt_ext);
        w_pos_last = (w_pos_p1 == w_cnt_ext);
        w_dst_m2   = CW'(r_dst) - CW'(2);
        w_dst_p2   = CW'(r_dst) + CW'(2);
        w_ins_last = (CW'(r_dst) == (CW'(r_pos) + CW'(1)));
        w_rem_last = (w_dst_p2 == r_count);
    end

    // outputs and datapath next values
    always_comb begin
        logic [CW-1:0] v_cnt;
        logic [EW-1:0] v_len;
        t_res          v_res;

        o_in_ready = (r_state == S_IDLE);
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_data  = '0;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;
        o_fin_valid = 1'b0;
        v_cnt      = r_count;
        v_res.read_value = '0;
        v_res.text_length = '0;
        v_res.status = ST_OK;
        n_dst = r_dst;
        n_pos = r_pos;
        n_val = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pos = w_pos_ext[AW-1:0];
                    n_val = i_byte_value;
                    unique case (i_op)
                        OP_APPEND: begin
                            o_fin_valid = 1'b1;
                            v_cnt = w_eff;
                            if (w_cr) begin
                                v_res.status = ST_CR;
                            end else if (w_app_full) begin
                                v_res.status = ST_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = w_eff[AW-1:0];
                                o_wr_data = i_byte_value;
                                v_cnt     = w_eff + CW'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (w_ins_bad) begin
                                o_fin_valid  = 1'b1;
                                v_res.status = ST_RANGE;
                            end else if (w_full) begin
                                o_fin_valid  = 1'b1;
                                v_res.status = ST_FULL;
                            end else if (w_pos_eq) begin
                                // insert at the end: no tail to move
                                o_fin_valid = 1'b1;
                                o_wr_en     = 1'b1;
                                o_wr_addr   = w_pos_ext[AW-1:0];
                                o_wr_data   = i_byte_value;
                                v_cnt       = r_count + CW'(1);
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_cnt_m1[AW-1:0];
                                n_dst     = r_count[AW-1:0];
                            end
                        end
                        OP_REMOVE: begin
                            if (w_pos_bad) begin
                                o_fin_valid  = 1'b1;
                                v_res.status = ST_RANGE;
                            end else if (w_pos_last) begin
                                o_fin_valid = 1'b1;
                                v_cnt       = w_cnt_m1;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_pos_p1[AW-1:0];
                                n_dst     = w_pos_ext[AW-1:0];
                            end
                        end
                        OP_READ: begin
                            if (w_pos_bad) begin
                                o_fin_valid  = 1'b1;
                                v_res.status = ST_RANGE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_pos_ext[AW-1:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                // move entry dst-1 (read last cycle) up to dst
                o_wr_en   = 1'b1;
                o_wr_addr = r_dst;
                o_wr_data = i_rd_data;
                if (!w_ins_last) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_dst_m2[AW-1:0];
                end
                n_dst = r_dst - AW'(1);
            end
            S_PUT: begin
                o_wr_en     = 1'b1;
                o_wr_addr   = r_pos;
                o_wr_data   = r_val;
                o_fin_valid = 1'b1;
                v_cnt       = r_count + CW'(1);
            end
            S_REM: begin
                // move entry dst+1 (read last cycle) down to dst
                o_wr_en   = 1'b1;
                o_wr_addr = r_dst;
                o_wr_data = i_rd_data;
                if (w_rem_last) begin
                    o_fin_valid = 1'b1;
                    v_cnt       = w_cnt_m1;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_dst_p2[AW-1:0];
                end
                n_dst = r_dst + AW'(1);
            end
            S_RD: begin
                o_fin_valid      = 1'b1;
                v_res.read_value = i_rd_data;
            end
            S_DONE: begin
                o_fin_valid = 1'b1;
            end
            default: ;
        endcase

        v_len = EW'(v_cnt);
        v_res.text_length = v_len[LEN_W-1:0];
        n_count = v_cnt;
        if (r_state == S_DONE) begin
            o_fin = r_res;
            n_res = r_res;
        end else begin
            o_fin = v_res;
            n_res = v_res;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (o_fin_valid) begin
                        n_state = i_slot_free ? S_IDLE : S_DONE;
                    end else begin
                        unique case (i_op)
                            OP_INSERT: n_state = S_INS;
                            OP_REMOVE: n_state = S_REM;
                            OP_READ:   n_state = S_RD;
                            default:   n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_INS: begin
                n_state = w_ins_last ? S_PUT : S_INS;
            end
            S_REM: begin
                if (w_rem_last) begin
                    n_state = i_slot_free ? S_IDLE : S_DONE;
                end
            end
            S_PUT, S_RD, S_DONE: begin
                n_state = i_slot_free ? S_IDLE : S_DONE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst <= n_dst;
        r_pos <= n_pos;
        r_val <= n_val;
        r_res <= n_res;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("character count above capacity");

    a_ins_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS |-> CW'(r_dst) > CW'(r_pos))
        else $error("insert shift ran past the insert position");

    a_port_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en && o_rd_en |-> o_wr_addr != o_rd_addr)
        else $error("read and write hit the same entry in one cycle");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !i_slot_free |=> r_state == S_DONE && $stable(r_res))
        else $error("pending result lost while output stalled");

endmodule

`default_nettype wire

### hw/rtl/char_insert_delete_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake                    | Payload
// in      | i_in_valid / o_in_ready      | i_op, i_start_req, i_position, i_byte_value
// out     | o_out_valid / i_out_ready    | o_read_value, o_text_length, o_status
//
// Append, rejected items, insert at the end and remove of the last character finish
// when accepted. Insert moves the tail up, then writes the byte; remove moves it down.
// One tail entry moves per cycle, through the single read and single write store port.
// A finished result waits in a skid slot if the output register is still occupied.
// Synchronous active-low reset clears the length and control; store contents stay.

module char_insert_delete_buffer #(
    parameter int CAPACITY = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [cidb_pkg::OP_W-1:0]     i_op,
    input  wire logic                          i_start_req,
    input  wire logic [cidb_pkg::POS_W-1:0]    i_position,
    input  wire logic [cidb_pkg::BYTE_W-1:0]   i_byte_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [cidb_pkg::BYTE_W-1:0]   o_read_value,
    output logic      [cidb_pkg::LEN_W-1:0]    o_text_length,
    output logic      [cidb_pkg::STAT_W-1:0]   o_status
);
    import cidb_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              w_slot_free;
    logic              w_fin_valid;
    t_res              w_fin;
    logic              w_wr_en, w_rd_en;
    logic [AW-1:0]     w_wr_addr, w_rd_addr;
    logic [BYTE_W-1:0] w_wr_data, w_rd_data;

    logic r_out_valid, n_out_valid;
    t_res r_out, n_out;

    cidb_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (t_op'(i_op)),
        .i_start_req  (i_start_req),
        .i_position   (i_position),
        .i_byte_value (i_byte_value),
        .i_slot_free  (w_slot_free),
        .o_fin_valid  (w_fin_valid),
        .o_fin        (w_fin),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data)
    );

    cidb_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // output register: loads when empty or being drained this cycle
    always_comb begin
        w_slot_free = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (w_fin_valid && w_slot_free) begin
            n_out_valid = 1'b1;
            n_out       = w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out.read_value;
    assign o_text_length = r_out.text_length;
    assign o_status      = r_out.status;

endmodule

`default_nettype wire

### tb/char_insert_delete_buffer_tb.sv
`timescale 1ns / 1ps

module char_insert_delete_buffer_tb;
    import cidb_pkg::*;

    localparam int CAP          = 256;
    localparam int RANDOM_ITEMS = 1900;
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    typedef enum {SEQ_LOAD, SEQ_EDIT, SEQ_FILL, SEQ_NOISE} t_seq;

    // Tracks the text held by the buffer and the results still owed by it.
    class edit_scoreboard;
        logic [BYTE_W-1:0] text_mem [CAP];
        int unsigned       text_len;
        t_res              expected_q [$];
        int unsigned       errors;
        int unsigned       reports;

        function new();
            text_len = 0;
            errors   = 0;
            reports  = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic start, logic [POS_W-1:0] pos,
                                 logic [BYTE_W-1:0] val);
            t_res        res;
            int unsigned p;
            int unsigned i;
            res.read_value = '0;
            res.status     = ST_OK;
            p = pos;
            case (t_op'(op))
                OP_APPEND: begin
                    if (start)
                        text_len = 0;
                    if (val == CR_BYTE) begin
                        res.status = ST_CR;
                    end else if (text_len >= CAP) begin
                        res.status = ST_FULL;
                    end else begin
                        text_mem[text_len] = val;
                        text_len++;
                    end
                end
                OP_INSERT: begin
                    // range check wins over the full check
                    if (p > text_len) begin
                        res.status = ST_RANGE;
                    end else if (text_len >= CAP) begin
                        res.status = ST_FULL;
                    end else begin
                        for (i = text_len; i > p; i--)
                            text_mem[i] = text_mem[i-1];
                        text_mem[p] = val;
                        text_len++;
                    end
                end
                OP_REMOVE: begin
                    if (p >= text_len) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (i = p; i + 1 < text_len; i++)
                            text_mem[i] = text_mem[i+1];
                        text_len--;
                    end
                end
                default: begin
                    if (p >= text_len)
                        res.status = ST_RANGE;
                    else
                        res.read_value = text_mem[p];
                end
            endcase
            res.text_length = text_len[LEN_W-1:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [BYTE_W-1:0] rd, logic [LEN_W-1:0] len,
                                   logic [STAT_W-1:0] st);
            t_res exp_res;
            if (expected_q.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS)
                    $display("unexpected result: rd %02h len %0d st %0d", rd, len, st);
                reports++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (rd !== exp_res.read_value || len !== exp_res.text_length ||
                st !== exp_res.status) begin
                errors++;
                if (reports < MAX_REPORTS)
                    $display({"mismatch: expected rd %02h len %0d st %0d, ",
                              "got rd %02h len %0d st %0d"},
                             exp_res.read_value, exp_res.text_length, exp_res.status,
                             rd, len, st);
                reports++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op;
    logic                i_start_req;
    logic [POS_W-1:0]    i_position;
    logic [BYTE_W-1:0]   i_byte_value;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [BYTE_W-1:0]   o_read_value;
    logic [LEN_W-1:0]    o_text_length;
    logic [STAT_W-1:0]   o_status;

    edit_scoreboard      board;
    bit                  idle_on = 1'b1;
    int unsigned         sent = 0;
    int unsigned         quiet_cycles = 0;

    char_insert_delete_buffer #(.CAPACITY(CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_start_req   (i_start_req),
        .i_position    (i_position),
        .i_byte_value  (i_byte_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_text_length (o_text_length),
        .o_status      (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // output checking and watchdog count
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_read_value, o_text_length, o_status);
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // result side back-pressure
    initial begin
        int unsigned k;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 6) == 0) begin
                k = $urandom_range(1, 5);
                i_out_ready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        return ($urandom_range(0, 11) == 0) ? CR_BYTE : BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(t_op op, bit start, logic [POS_W-1:0] pos,
                             logic [BYTE_W-1:0] val);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_start_req  <= start;
        i_position   <= pos;
        i_byte_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(op, start, pos, val);
        sent++;
    endtask

    // hold off the sender until every owed result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // one edit with a position mostly inside the text, biased to its ends
    task automatic edit_item();
        int unsigned len;
        int unsigned roll;
        int unsigned pos;
        int unsigned top;
        t_op         op;
        bit          start;
        len  = board.text_len;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            op = OP_APPEND;
        else if (roll < 50)
            op = OP_INSERT;
        else if (roll < 75)
            op = OP_REMOVE;
        else
            op = OP_READ;
        top = (op == OP_INSERT) ? len : ((len == 0) ? 0 : len - 1);
        if ($urandom_range(0, 99) < 12) begin
            pos = (op == OP_INSERT) ? $urandom_range(len + 1, 511) : $urandom_range(len, 511);
        end else begin
            roll = $urandom_range(0, 3);
            pos  = (roll == 0) ? 0 : (roll == 1) ? top : $urandom_range(0, top);
        end
        start = (op == OP_APPEND) ? ($urandom_range(0, 15) == 0) : 1'($urandom_range(0, 1));
        send_item(op, start, pos[POS_W-1:0], pick_byte());
    endtask

    initial begin
        int unsigned target;
        bit          first_seq;
        bit          paused;
        t_seq        seq;
        int unsigned roll;

        board        = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_APPEND;
        i_start_req  = 1'b0;
        i_position   = '0;
        i_byte_value = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, ends of the text, CR handling, ignored start flag
        send_item(OP_READ,   0, 9'd0,   8'h11);
        send_item(OP_REMOVE, 0, 9'd0,   8'h22);
        send_item(OP_INSERT, 0, 9'd1,   8'h33);
        send_item(OP_INSERT, 0, 9'h1FF, 8'hFF);
        send_item(OP_INSERT, 1, 9'd0,   8'h00);
        send_item(OP_APPEND, 0, 9'h1FF, 8'hFF);
        send_item(OP_APPEND, 0, 9'd0,   CR_BYTE);
        send_item(OP_INSERT, 0, 9'd2,   CR_BYTE);
        send_item(OP_INSERT, 0, 9'd1,   8'h80);
        send_item(OP_READ,   1, 9'd0,   8'h00);
        send_item(OP_READ,   0, 9'd3,   8'h00);
        send_item(OP_READ,   0, 9'd4,   8'h00);
        send_item(OP_READ,   0, 9'd256, 8'h00);
        send_item(OP_REMOVE, 1, 9'd0,   8'h00);
        send_item(OP_REMOVE, 0, 9'd2,   8'h00);
        send_item(OP_REMOVE, 0, 9'd2,   8'h00);
        send_item(OP_APPEND, 1, 9'd0,   CR_BYTE);
        send_item(OP_APPEND, 1, 9'd0,   8'h5A);
        send_item(OP_APPEND, 0, 9'd0,   8'hA5);
        send_item(OP_INSERT, 0, 9'd0,   8'h7F);
        send_item(OP_READ,   0, 9'd1,   8'h00);
        send_item(OP_REMOVE, 0, 9'd1,   8'h00);
        send_item(OP_READ,   0, 9'd1,   8'h00);
        drain();

        target    = sent + RANDOM_ITEMS;
        first_seq = 1'b1;
        paused    = 1'b0;
        while (sent < target) begin
            if (sent + 200 >= target)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            if (!paused && sent + RANDOM_ITEMS / 2 >= target) begin
                drain();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 63);
            if (first_seq || roll == 0)
                seq = SEQ_FILL;
            else if (roll < 20)
                seq = SEQ_LOAD;
            else if (roll < 56)
                seq = SEQ_EDIT;
            else
                seq = SEQ_NOISE;
            first_seq = 1'b0;
            case (seq)
                SEQ_LOAD: begin
                    send_item(OP_APPEND, 1, POS_W'($urandom_range(0, 511)), pick_byte());
                    repeat ($urandom_range(0, 40))
                        send_item(OP_APPEND, 0, POS_W'($urandom_range(0, 511)), pick_byte());
                end
                SEQ_FILL: begin
                    send_item(OP_APPEND, 1, POS_W'($urandom_range(0, 511)), pick_byte());
                    while (board.text_len < CAP)
                        send_item(OP_APPEND, 0, POS_W'($urandom_range(0, 511)), pick_byte());
                    repeat (3)
                        send_item(OP_APPEND, 0, 9'd0, BYTE_W'($urandom_range(0, 255)));
                    send_item(OP_INSERT, 0, POS_W'(CAP), 8'h41);
                    send_item(OP_INSERT, 0, POS_W'(CAP + 1), 8'h42);
                    send_item(OP_READ,   0, POS_W'(CAP - 1), 8'h00);
                    repeat (12) edit_item();
                end
                SEQ_EDIT: begin
                    repeat ($urandom_range(5, 30)) edit_item();
                end
                default: begin
                    repeat ($urandom_range(1, 8))
                        send_item(t_op'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  POS_W'($urandom_range(0, 511)),
                                  BYTE_W'($urandom_range(0, 255)));
                end
            endcase
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
